// File: src/bgpio_pkg.sv
// ----------------------------------------------------------------------------
// bgpio_pkg
// shared types, offsets and codes of the banked gpio register block
// ----------------------------------------------------------------------------
package bgpio_pkg;

  // defaults for the top level parameters
  localparam int unsigned NumBanksDef  = 4;
  localparam int unsigned BankWidthDef = 32;

  // bank number as carried between modules, wide enough for eight banks
  localparam int unsigned BankIdxW = 3;

  // register map, byte offsets
  localparam logic [9:0] OfsMaskLow  = 10'h000;
  localparam logic [9:0] OfsMaskHigh = 10'h004;
  localparam logic [9:0] OfsData     = 10'h040;
  localparam logic [9:0] OfsDataRo   = 10'h060;
  localparam logic [9:0] OfsDirm     = 10'h204;
  localparam logic [9:0] OfsOuten    = 10'h208;
  localparam int unsigned CtrlStride = 'h40;
  localparam int unsigned HalfPins      = 16;
  localparam int unsigned ShortBankPins = 22;

  typedef enum logic [1:0] {
    ReqRead   = 2'd0,
    ReqWrite  = 2'd1,
    ReqSample = 2'd2,
    ReqNop    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KindNone,
    KindLow,
    KindHigh,
    KindData,
    KindDataRo,
    KindDirm,
    KindOuten
  } kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  address;
    logic [31:0] write_data;
    logic [1:0]  sample_bank;
    logic [31:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic [1:0]  drive_bank;
    logic [31:0] drive_levels;
    logic [31:0] drive_enables;
  } rsp_t;

  // address decode result
  typedef struct packed {
    kind_e               kind;
    logic [BankIdxW-1:0] bank;
  } dec_t;

endpackage

// File: src/bgpio_req_if.sv
// ----------------------------------------------------------------------------
// bgpio_req_if
// request channel: valid/ready handshake carrying one access or pin sample
// ----------------------------------------------------------------------------
interface bgpio_req_if;
  logic             valid;
  logic             ready;
  bgpio_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/bgpio_rsp_if.sv
// ----------------------------------------------------------------------------
// bgpio_rsp_if
// result channel: valid/ready handshake carrying read data and bank drive
// ----------------------------------------------------------------------------
interface bgpio_rsp_if;
  logic             valid;
  logic             ready;
  bgpio_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/bgpio_decode.sv
// ----------------------------------------------------------------------------
// bgpio_decode
// maps a byte offset to a register kind and bank
// ----------------------------------------------------------------------------
module bgpio_decode #(
  parameter int unsigned NUM_BANKS = bgpio_pkg::NumBanksDef
) (
  input  logic [9:0]        addr_i,
  output bgpio_pkg::dec_t   dec_o
);

  localparam logic [9:0] MaskEnd  = 10'(8 * NUM_BANKS);
  localparam logic [9:0] DataEnd  = 10'(bgpio_pkg::OfsData + 4 * NUM_BANKS);
  localparam logic [9:0] DataRoEnd = 10'(bgpio_pkg::OfsDataRo + 4 * NUM_BANKS);
  localparam logic [5:0] OutenRel =
    6'(bgpio_pkg::OfsOuten - bgpio_pkg::OfsDirm);

  logic [9:0] data_off;
  logic [9:0] ro_off;
  logic [9:0] ctrl_off;

  assign data_off = addr_i - bgpio_pkg::OfsData;
  assign ro_off   = addr_i - bgpio_pkg::OfsDataRo;
  assign ctrl_off = addr_i - bgpio_pkg::OfsDirm;

  always_comb begin
    dec_o.kind = bgpio_pkg::KindNone;
    dec_o.bank = '0;
    if (addr_i[1:0] != 2'b00) begin
      dec_o.kind = bgpio_pkg::KindNone;
    end else if (addr_i < MaskEnd) begin
      dec_o.bank = addr_i[5:3];
      dec_o.kind = addr_i[2] ? bgpio_pkg::KindHigh : bgpio_pkg::KindLow;
    end else if (addr_i >= bgpio_pkg::OfsData && addr_i < DataEnd) begin
      dec_o.bank = data_off[4:2];
      dec_o.kind = bgpio_pkg::KindData;
    end else if (addr_i >= bgpio_pkg::OfsDataRo && addr_i < DataRoEnd) begin
      dec_o.bank = ro_off[4:2];
      dec_o.kind = bgpio_pkg::KindDataRo;
    end else if (addr_i >= bgpio_pkg::OfsDirm && ctrl_off[9:6] < 4'(NUM_BANKS)) begin
      // per-bank control block on a 0x40 stride
      if (ctrl_off[5:0] == 6'd0) begin
        dec_o.bank = ctrl_off[8:6];
        dec_o.kind = bgpio_pkg::KindDirm;
      end else if (ctrl_off[5:0] == OutenRel) begin
        dec_o.bank = ctrl_off[8:6];
        dec_o.kind = bgpio_pkg::KindOuten;
      end
    end
  end

endmodule

// File: src/bgpio_bank_regs.sv
// ----------------------------------------------------------------------------
// bgpio_bank_regs
// per-bank latch, direction, enable and sample registers with access logic
// ----------------------------------------------------------------------------
module bgpio_bank_regs #(
  parameter int unsigned NUM_BANKS  = bgpio_pkg::NumBanksDef,
  parameter int unsigned BANK_WIDTH = bgpio_pkg::BankWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  bgpio_pkg::req_t  req_i,
  input  bgpio_pkg::dec_t  dec_i,
  output bgpio_pkg::rsp_t  rsp_o
);

  localparam int unsigned Biw = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int unsigned Hp  = bgpio_pkg::HalfPins;

  logic [BANK_WIDTH-1:0] latch_q [NUM_BANKS];
  logic [BANK_WIDTH-1:0] dir_q   [NUM_BANKS];
  logic [BANK_WIDTH-1:0] oen_q   [NUM_BANKS];
  logic [BANK_WIDTH-1:0] samp_q  [NUM_BANKS];

  logic [bgpio_pkg::BankIdxW-1:0] bank;
  logic [Biw-1:0]        idx;
  logic [BANK_WIDTH-1:0] pm;
  logic [BANK_WIDTH-1:0] wd;
  logic [31:0]           sel32;
  logic [31:0]           dat32;
  logic [BANK_WIDTH-1:0] mwe;
  logic [BANK_WIDTH-1:0] mdat;
  logic [BANK_WIDTH-1:0] latch_d;
  logic [BANK_WIDTH-1:0] dir_d;
  logic [BANK_WIDTH-1:0] oen_d;
  logic [BANK_WIDTH-1:0] samp_d;
  logic                  we_latch;
  logic                  we_dir;
  logic                  we_oen;
  logic                  we_samp;
  logic [31:0]           rdata;
  logic                  err;

  // existing pins of the addressed bank, bank 1 is short
  always_comb begin
    for (int i = 0; i < BANK_WIDTH; i++) begin
      pm[i] = !(idx == Biw'(1) && i >= bgpio_pkg::ShortBankPins);
    end
  end

  // bank selection and error flag
  always_comb begin
    bank = '0;
    err  = 1'b0;
    if (req_i.req_type == bgpio_pkg::ReqRead || req_i.req_type == bgpio_pkg::ReqWrite) begin
      if (dec_i.kind == bgpio_pkg::KindNone) begin
        err = 1'b1;
      end else begin
        bank = dec_i.bank;
        if (req_i.req_type == bgpio_pkg::ReqRead &&
            (dec_i.kind == bgpio_pkg::KindLow || dec_i.kind == bgpio_pkg::KindHigh)) begin
          err = 1'b1;
        end
      end
    end else if (req_i.req_type == bgpio_pkg::ReqSample) begin
      if ({2'b00, req_i.sample_bank} < 4'(NUM_BANKS)) begin
        bank = bgpio_pkg::BankIdxW'(req_i.sample_bank);
      end
    end
  end

  assign idx = bank[Biw-1:0];
  assign wd  = req_i.write_data[BANK_WIDTH-1:0] & pm;

  // masked word: mask bit zero selects the data bit
  always_comb begin
    if (dec_i.kind == bgpio_pkg::KindHigh) begin
      sel32 = {~req_i.write_data[31:Hp], 16'h0000};
      dat32 = {req_i.write_data[Hp-1:0], 16'h0000};
    end else begin
      sel32 = {16'h0000, ~req_i.write_data[31:Hp]};
      dat32 = {16'h0000, req_i.write_data[Hp-1:0]};
    end
  end

  assign mwe  = sel32[BANK_WIDTH-1:0] & pm;
  assign mdat = dat32[BANK_WIDTH-1:0];

  always_comb begin
    latch_d  = latch_q[idx];
    dir_d    = dir_q[idx];
    oen_d    = oen_q[idx];
    samp_d   = samp_q[idx];
    we_latch = 1'b0;
    we_dir   = 1'b0;
    we_oen   = 1'b0;
    we_samp  = 1'b0;
    rdata    = '0;
    if (req_i.req_type == bgpio_pkg::ReqRead) begin
      case (dec_i.kind)
        bgpio_pkg::KindData:   rdata = 32'(latch_q[idx]);
        bgpio_pkg::KindDataRo: rdata = 32'(samp_q[idx]);
        bgpio_pkg::KindDirm:   rdata = 32'(dir_q[idx]);
        bgpio_pkg::KindOuten:  rdata = 32'(oen_q[idx]);
        default:               rdata = '0;
      endcase
    end else if (req_i.req_type == bgpio_pkg::ReqWrite) begin
      case (dec_i.kind)
        bgpio_pkg::KindLow, bgpio_pkg::KindHigh: begin
          latch_d  = (latch_q[idx] & ~mwe) | (mdat & mwe);
          we_latch = 1'b1;
        end
        bgpio_pkg::KindData: begin
          latch_d  = wd;
          we_latch = 1'b1;
        end
        bgpio_pkg::KindDirm: begin
          dir_d  = wd;
          we_dir = 1'b1;
        end
        bgpio_pkg::KindOuten: begin
          oen_d  = wd;
          we_oen = 1'b1;
        end
        default: ;
      endcase
    end else if (req_i.req_type == bgpio_pkg::ReqSample) begin
      if ({2'b00, req_i.sample_bank} < 4'(NUM_BANKS)) begin
        samp_d  = req_i.pin_levels[BANK_WIDTH-1:0] & pm;
        we_samp = 1'b1;
      end
    end
  end

  // drive report reflects state after this item
  assign rsp_o.read_data     = rdata;
  assign rsp_o.access_error  = err;
  assign rsp_o.drive_bank    = bank[1:0];
  assign rsp_o.drive_levels  = 32'(latch_d);
  assign rsp_o.drive_enables = 32'(dir_d & oen_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        latch_q[b] <= '0;
        dir_q[b]   <= '0;
        oen_q[b]   <= '0;
        samp_q[b]  <= '0;
      end
    end else if (upd_i) begin
      if (we_latch) latch_q[idx] <= latch_d;
      if (we_dir)   dir_q[idx]   <= dir_d;
      if (we_oen)   oen_q[idx]   <= oen_d;
      if (we_samp)  samp_q[idx]  <= samp_d;
    end
  end

endmodule

// File: src/banked_gpio_masked_write_regs.sv
// ----------------------------------------------------------------------------
// banked_gpio_masked_write_regs
// register block of a banked gpio controller with masked output writes
// ----------------------------------------------------------------------------
// usage
//   req_i carries one item per handshake: a bus read, a bus write or a pin
//   sample of one bank. rsp_o returns exactly one item per request, in order,
//   with read data, an access error flag and the drive levels and enables of
//   the bank touched (bank 0 when nothing was addressed)
//   an item taken into the input register moves on into the result register
//   when that is free or being emptied, and its result is offered from there
//   throughput is one item per cycle unless stalled; the input and result
//   register form two stages, so a new item is taken while a result waits
//   when the receiver stalls, the result holds and the staged item waits in
//   the input register; req_i.ready drops only when both stages are full
//   reset clears all latches, directions (all inputs), enables and samples,
//   and empties both stages; the block is ready in the first cycle after it
// ----------------------------------------------------------------------------
module banked_gpio_masked_write_regs #(
  parameter int unsigned NUM_BANKS  = bgpio_pkg::NumBanksDef,
  parameter int unsigned BANK_WIDTH = bgpio_pkg::BankWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bgpio_req_if.sink     req_i,
  bgpio_rsp_if.source   rsp_o
);

  // input stage
  logic            in_valid_q;
  logic            in_valid_d;
  bgpio_pkg::req_t req_q;

  // result stage
  logic            out_valid_q;
  logic            out_valid_d;
  bgpio_pkg::rsp_t rsp_q;

  bgpio_pkg::dec_t dec;
  bgpio_pkg::rsp_t rsp_calc;
  logic            load;
  logic            advance;

  // staged item moves on when the result register is free or being emptied
  assign advance     = in_valid_q & (~out_valid_q | rsp_o.ready);
  assign req_i.ready = ~in_valid_q | advance;
  assign load        = req_i.valid & req_i.ready;

  assign in_valid_d  = load ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i.data;
    end
    if (advance) begin
      rsp_q <= rsp_calc;
    end
  end

  // offset decode of the staged item
  bgpio_decode #(
    .NUM_BANKS (NUM_BANKS)
  ) u_decode (
    .addr_i (req_q.address),
    .dec_o  (dec)
  );

  // bank state and the access itself; state updates as the item moves on
  bgpio_bank_regs #(
    .NUM_BANKS  (NUM_BANKS),
    .BANK_WIDTH (BANK_WIDTH)
  ) u_bank_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance),
    .req_i  (req_q),
    .dec_i  (dec),
    .rsp_o  (rsp_calc)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

  // an error never comes with read data
  a_err_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.access_error |-> rsp_o.data.read_data == 32'h0)
    else $error("read data on an access error");

  // an empty result stage never holds back the input
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("input stalled with empty result stage");

  // reported bank exists
  a_bank_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> {2'b00, rsp_o.data.drive_bank} < 4'(NUM_BANKS))
    else $error("drive report for a missing bank");

  // the short bank never drives its missing pins
  a_short_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.drive_bank == 2'd1 |->
      rsp_o.data.drive_levels[31:bgpio_pkg::ShortBankPins] == '0 &&
      rsp_o.data.drive_enables[31:bgpio_pkg::ShortBankPins] == '0)
    else $error("bank 1 drives a missing pin");

endmodule

// File: tb/bgpio_access_checker.sv
// ----------------------------------------------------------------------------
// bgpio_access_checker
// watches both channels of the banked gpio register block, keeps shadow
// copies of the bank registers, predicts each result and compares it
// ----------------------------------------------------------------------------
module bgpio_access_checker
  import bgpio_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBanks  = NumBanksDef;
  localparam int unsigned BankWidth = BankWidthDef;

  // shadow registers per bank
  logic [31:0] shadow_latch  [NumBanks];
  logic [31:0] shadow_dir    [NumBanks];
  logic [31:0] shadow_oen    [NumBanks];
  logic [31:0] shadow_sample [NumBanks];

  rsp_t        predicted_rsp_q [$];
  int unsigned mismatches;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = predicted_rsp_q.size();

  // pins that exist in a bank; bank 1 is the short one
  function automatic logic [31:0] bank_pins(input int unsigned b);
    int unsigned w;
    w = BankWidth;
    if (b == 1 && w > ShortBankPins) w = ShortBankPins;
    if (w >= 32) return '1;
    return (32'd1 << w) - 32'd1;
  endfunction

  function automatic kind_e decode_ofs(input logic [9:0] a, output int unsigned b);
    int unsigned off;
    int unsigned blk;
    int unsigned rem;
    b = 0;
    if (a[1:0] != 2'b00) return KindNone;
    if (a < OfsMaskLow + 8 * NumBanks) begin
      b = a >> 3;
      return a[2] ? KindHigh : KindLow;
    end
    if (a >= OfsData && a < OfsData + 4 * NumBanks) begin
      b = (a - OfsData) >> 2;
      return KindData;
    end
    if (a >= OfsDataRo && a < OfsDataRo + 4 * NumBanks) begin
      b = (a - OfsDataRo) >> 2;
      return KindDataRo;
    end
    if (a >= OfsDirm) begin
      off = a - OfsDirm;
      blk = off / CtrlStride;
      rem = off % CtrlStride;
      if (blk < NumBanks) begin
        b = blk;
        if (rem == 0) return KindDirm;
        if (rem == OfsOuten - OfsDirm) return KindOuten;
        b = 0;
      end
    end
    return KindNone;
  endfunction

  // applies one item to the shadow registers and returns its result
  function automatic rsp_t apply_access(input req_t it);
    rsp_t        r;
    kind_e       k;
    int unsigned b;
    int unsigned shift;
    logic [31:0] pm;
    logic [31:0] m;
    r = '0;
    b = 0;
    case (it.req_type)
      ReqRead, ReqWrite: begin
        k = decode_ofs(it.address, b);
        if (k == KindNone) begin
          r.access_error = 1'b1;
          b = 0;
        end else if (it.req_type == ReqRead) begin
          case (k)
            KindData:   r.read_data = shadow_latch[b];
            KindDataRo: r.read_data = shadow_sample[b];
            KindDirm:   r.read_data = shadow_dir[b];
            KindOuten:  r.read_data = shadow_oen[b];
            default:    r.access_error = 1'b1;
          endcase
        end else begin
          pm = bank_pins(b);
          case (k)
            KindLow, KindHigh: begin
              shift = (k == KindHigh) ? HalfPins : 0;
              // a data bit is taken where its mask bit is clear
              m = ({16'h0000, ~it.write_data[31:16]} << shift) & pm;
              shadow_latch[b] = (shadow_latch[b] & ~m) |
                                (({16'h0000, it.write_data[15:0]} << shift) & m);
            end
            KindData:  shadow_latch[b] = it.write_data & pm;
            KindDirm:  shadow_dir[b]   = it.write_data & pm;
            KindOuten: shadow_oen[b]   = it.write_data & pm;
            default: ;
          endcase
        end
      end
      ReqSample: begin
        b = it.sample_bank;
        if (b < NumBanks) shadow_sample[b] = it.pin_levels & bank_pins(b);
        else b = 0;
      end
      default: ;
    endcase
    r.drive_bank    = b[1:0];
    r.drive_levels  = shadow_latch[b];
    r.drive_enables = shadow_dir[b] & shadow_oen[b];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumBanks; i++) begin
        shadow_latch[i]  = '0;
        shadow_dir[i]    = '0;
        shadow_oen[i]    = '0;
        shadow_sample[i] = '0;
      end
      predicted_rsp_q.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (predicted_rsp_q.size() == 0) begin
          if (mismatches < 10) $display("%0t: result item with none pending", $time);
          mismatches++;
        end else begin
          want = predicted_rsp_q.pop_front();
          check_field("read_data", want.read_data, rsp_data_i.read_data);
          check_field("access_error", {31'b0, want.access_error},
                      {31'b0, rsp_data_i.access_error});
          check_field("drive_bank", {30'b0, want.drive_bank}, {30'b0, rsp_data_i.drive_bank});
          check_field("drive_levels", want.drive_levels, rsp_data_i.drive_levels);
          check_field("drive_enables", want.drive_enables, rsp_data_i.drive_enables);
        end
      end
      if (req_valid_i && req_ready_i) predicted_rsp_q.push_back(apply_access(req_data_i));
    end
  end

endmodule

// File: tb/tb_banked_gpio_masked_write_regs.sv
// ----------------------------------------------------------------------------
// tb_banked_gpio_masked_write_regs
// drives bus reads, bus writes and pin samples into the gpio register block,
// first a directed set over the register map and its corner cases, then
// weighted random traffic, with random idle bursts on both channels; the
// checker beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_banked_gpio_masked_write_regs;
  timeunit 1ns;
  timeprecision 1ps;

  import bgpio_pkg::*;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          idle_on;
  int unsigned mismatches;
  int unsigned outstanding;

  bgpio_req_if req_if ();
  bgpio_rsp_if rsp_if ();

  banked_gpio_masked_write_regs DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bgpio_access_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_data_i       (req_if.data),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_data_i       (rsp_if.data),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall bursts while idling is allowed, otherwise always ready
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic req_t mk_item(input req_e t, input logic [9:0] a, input logic [31:0] wd,
                                   input logic [1:0] sb, input logic [31:0] pl);
    req_t it;
    it.req_type    = t;
    it.address     = a;
    it.write_data  = wd;
    it.sample_bank = sb;
    it.pin_levels  = pl;
    return it;
  endfunction

  // byte offset of a register of one bank
  function automatic logic [9:0] reg_addr(input kind_e k, input int unsigned b);
    case (k)
      KindLow:    return 10'(OfsMaskLow + 8 * b);
      KindHigh:   return 10'(OfsMaskHigh + 8 * b);
      KindData:   return 10'(OfsData + 4 * b);
      KindDataRo: return 10'(OfsDataRo + 4 * b);
      KindDirm:   return 10'(OfsDirm + CtrlStride * b);
      KindOuten:  return 10'(OfsOuten + CtrlStride * b);
      default:    return 10'h3FC;
    endcase
  endfunction

  // offers one item and returns at the edge where it is taken
  task automatic push_item(input req_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  initial begin : stimulus
    req_e        t;
    logic [9:0]  a;
    logic [31:0] wd;
    int unsigned pick;

    rst_ni       = 1'b0;
    idle_on      = 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    // reset value, full writes, bank 1 trimmed to its 22 pins
    push_item(mk_item(ReqRead,  reg_addr(KindData, 0), '0, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindData, 0), 32'hFFFF_FFFF, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindData, 1), 32'hFFFF_FFFF, 2'd0, '0));
    push_item(mk_item(ReqRead,  reg_addr(KindData, 1), '0, 2'd0, '0));
    // masked words: partial mask, clear mask, high half of the short bank, full mask
    push_item(mk_item(ReqWrite, reg_addr(KindLow, 2),  32'h00FF_A5A5, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindHigh, 3), 32'h0000_FFFF, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindHigh, 1), 32'h0000_FFFF, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindLow, 1),  32'hFFFF_0000, 2'd0, '0));
    // masked words are write only
    push_item(mk_item(ReqRead,  reg_addr(KindLow, 2),  '0, 2'd0, '0));
    push_item(mk_item(ReqRead,  reg_addr(KindHigh, 0), '0, 2'd0, '0));
    // direction and enable, drive enables are their and
    push_item(mk_item(ReqWrite, reg_addr(KindDirm, 2),  32'hFFFF_FFFF, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindOuten, 2), 32'h0F0F_0F0F, 2'd0, '0));
    push_item(mk_item(ReqRead,  reg_addr(KindDirm, 2),  '0, 2'd0, '0));
    push_item(mk_item(ReqRead,  reg_addr(KindOuten, 2), '0, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindDirm, 1),  32'hFFFF_FFFF, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindOuten, 1), 32'hFFFF_FFFF, 2'd0, '0));
    // pin sample of the short bank, then a write to the read-only view is dropped
    push_item(mk_item(ReqSample, '0, '0, 2'd1, 32'hFFFF_FFFF));
    push_item(mk_item(ReqRead,  reg_addr(KindDataRo, 1), '0, 2'd0, '0));
    push_item(mk_item(ReqWrite, reg_addr(KindDataRo, 1), 32'h1234_5678, 2'd0, '0));
    // misaligned and unmapped offsets
    push_item(mk_item(ReqRead,  10'h3FF, '0, 2'd0, '0));
    push_item(mk_item(ReqWrite, 10'h3FC, 32'hFFFF_FFFF, 2'd0, '0));
    // last bank of the control area
    push_item(mk_item(ReqRead,  reg_addr(KindOuten, 3), '0, 2'd0, '0));
    push_item(mk_item(ReqRead,  reg_addr(KindDirm, 3),  '0, 2'd0, '0));
    // request type 3 does nothing; then a pin sample of the last bank
    push_item(mk_item(ReqNop, reg_addr(KindData, 2), 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
    push_item(mk_item(ReqSample, '0, '0, 2'd3, '0));

    // ---- random part ----
    for (int i = 0; i < RandomItems; i++) begin
      // idle phases come and go; the tail of the run is never idle
      if (i % 100 == 0) idle_on = (i < RandomItems - 150) && ($urandom_range(0, 3) != 0);

      pick = $urandom_range(0, 19);
      if (pick < 8)       t = ReqRead;
      else if (pick < 16) t = ReqWrite;
      else if (pick < 19) t = ReqSample;
      else                t = ReqNop;

      // mostly mapped registers, some raw offsets for decode errors
      if ($urandom_range(0, 6) == 0) a = 10'($urandom_range(0, 1023));
      else a = reg_addr(kind_e'($urandom_range(1, 6)), $urandom_range(0, NumBanksDef - 1));

      // masks at their extremes now and then
      case ($urandom_range(0, 5))
        0:       wd = '0;
        1:       wd = '1;
        2:       wd = $urandom & 32'h0000_FFFF;
        3:       wd = $urandom | 32'hFFFF_0000;
        default: wd = $urandom;
      endcase

      push_item(mk_item(t, a, wd, 2'($urandom_range(0, 3)), $urandom));
    end
    req_if.valid <= 1'b0;

    // let every result come back
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/bgpio_pkg.sv
src/bgpio_req_if.sv
src/bgpio_rsp_if.sv
src/bgpio_decode.sv
src/bgpio_bank_regs.sv
src/banked_gpio_masked_write_regs.sv
tb/bgpio_access_checker.sv
tb/tb_banked_gpio_masked_write_regs.sv
